// File: src/cma_pkg.sv
package cma_pkg;

    localparam int WORD_W        = 64;
    localparam int CMD_W         = 2;
    localparam int unsigned SCALE_DEFAULT = 1000;

    localparam logic [CMD_W-1:0] CMD_ADD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SUB = 2'd1;
    localparam logic [CMD_W-1:0] CMD_NEG = 2'd2;
    localparam logic [CMD_W-1:0] CMD_MUL = 2'd3;

    localparam logic [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        logic  is_mul;
        logic  neg;
        logic  fail;
        logic  simple_ok;
        word_t simple_val;
    } side_t;

endpackage

// File: src/cma_req_if.sv
interface cma_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [cma_pkg::CMD_W-1:0]            cmd;
    logic signed [cma_pkg::WORD_W-1:0]    operand_a;
    logic signed [cma_pkg::WORD_W-1:0]    operand_b;

    modport source (output valid, cmd, operand_a, operand_b, input ready);
    modport sink   (input valid, cmd, operand_a, operand_b, output ready);
endinterface

// File: src/cma_rsp_if.sv
interface cma_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 ok;
    logic signed [cma_pkg::WORD_W-1:0]    value;

    modport source (output valid, ok, value, input ready);
    modport sink   (input valid, ok, value, output ready);
endinterface

// File: src/checked_money_alu_core.sv
// Overflow-checked ALU on signed 64-bit amounts: add, subtract, negate, and a
// rate-times-quantity multiply that divides by SCALE with rounding half away
// from zero. A failed operation returns ok=0 and value 0. The block takes one
// beat per cycle while its skid register is empty and returns one result beat
// per request beat, in order. Every beat passes through the stages of the
// multiply path: sign and magnitude stage, four 32x32 partial products, two
// summing stages for the product, then division by SCALE as a multiply by its
// reciprocal: four 32x32 partial products, two summing stages for the quotient
// estimate, a remainder multiply and a remainder subtract, one stage that
// corrects the estimate and rounds, and the output register. A skid register
// behind the output keeps one more result when the output is held, after which
// the request side stalls.
module checked_money_alu_core #(
    parameter int unsigned SCALE = cma_pkg::SCALE_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    cma_req_if.sink   req,
    cma_rsp_if.source rsp
);

    localparam int W = cma_pkg::WORD_W;
    localparam int H = W / 2;
    localparam logic [W-1:0] RECIP   = {W{1'b1}} / W'(SCALE);
    localparam logic [H-1:0] DIVISOR = H'(SCALE);
    localparam logic [H-1:0] HALF_UP = H'((SCALE + 1) / 2);

    logic en;

    // stage 1: add, subtract, negate and magnitudes
    logic                 s1_valid_reg, s1_valid_next;
    cma_pkg::side_t       s1_side_reg, s1_side_next;
    cma_pkg::word_t       s1_ma_reg, s1_ma_next;
    cma_pkg::word_t       s1_mb_reg, s1_mb_next;

    cma_pkg::word_t a_u, b_u, sum, diff, nega;
    logic           add_ovf, sub_ovf;

    always_comb
    begin
        a_u     = req.operand_a;
        b_u     = req.operand_b;
        sum     = a_u + b_u;
        diff    = a_u - b_u;
        nega    = ~a_u + W'(1);
        add_ovf = ((a_u ^ sum) & (b_u ^ sum)) >> (W - 1) != '0;
        sub_ovf = ((a_u ^ b_u) & (a_u ^ diff)) >> (W - 1) != '0;

        s1_valid_next           = req.valid;
        s1_side_next.is_mul     = 1'b0;
        s1_side_next.neg        = a_u[W-1] ^ b_u[W-1];
        s1_side_next.fail       = 1'b0;
        s1_side_next.simple_ok  = 1'b0;
        s1_side_next.simple_val = '0;
        case (req.cmd)
            cma_pkg::CMD_ADD:
            begin
                s1_side_next.simple_ok  = !add_ovf;
                s1_side_next.simple_val = sum;
            end
            cma_pkg::CMD_SUB:
            begin
                s1_side_next.simple_ok  = (b_u != cma_pkg::WORD_MIN) && !sub_ovf;
                s1_side_next.simple_val = diff;
            end
            cma_pkg::CMD_NEG:
            begin
                s1_side_next.simple_ok  = (a_u != cma_pkg::WORD_MIN);
                s1_side_next.simple_val = nega;
            end
            default:
            begin
                s1_side_next.is_mul = 1'b1;
            end
        endcase
        s1_ma_next = a_u[W-1] ? nega : a_u;
        s1_mb_next = b_u[W-1] ? (~b_u + W'(1)) : b_u;
    end

    // stage 2: partial products
    logic           s2_valid_reg, s2_valid_next;
    cma_pkg::side_t s2_side_reg, s2_side_next;
    cma_pkg::word_t pp00_reg, pp00_next;
    cma_pkg::word_t pp01_reg, pp01_next;
    cma_pkg::word_t pp10_reg, pp10_next;
    cma_pkg::word_t pp11_reg, pp11_next;

    always_comb
    begin
        s2_valid_next = s1_valid_reg;
        s2_side_next  = s1_side_reg;
        pp00_next     = W'(s1_ma_reg[H-1:0] * s1_mb_reg[H-1:0]);
        pp01_next     = W'(s1_ma_reg[H-1:0] * s1_mb_reg[W-1:H]);
        pp10_next     = W'(s1_ma_reg[W-1:H] * s1_mb_reg[H-1:0]);
        pp11_next     = W'(s1_ma_reg[W-1:H] * s1_mb_reg[W-1:H]);
    end

    // stage 3: middle terms
    logic           s3_valid_reg, s3_valid_next;
    cma_pkg::side_t s3_side_reg, s3_side_next;
    logic [W:0]     s3_mid_reg, s3_mid_next;
    cma_pkg::word_t s3_lo_reg, s3_lo_next;

    always_comb
    begin
        s3_valid_next      = s2_valid_reg;
        s3_side_next       = s2_side_reg;
        s3_side_next.fail  = s2_side_reg.fail | (pp11_reg != '0);
        s3_mid_next        = {1'b0, pp01_reg} + {1'b0, pp10_reg};
        s3_lo_next         = pp00_reg;
    end

    // stage 4: full product, fails past 64 bits
    logic           s4_valid_reg, s4_valid_next;
    cma_pkg::side_t s4_side_reg, s4_side_next;
    cma_pkg::word_t s4_prod_reg, s4_prod_next;
    logic [W:0]     prod_hi;

    always_comb
    begin
        prod_hi           = s3_mid_reg + (W + 1)'(s3_lo_reg[W-1:H]);
        s4_valid_next     = s3_valid_reg;
        s4_side_next      = s3_side_reg;
        s4_side_next.fail = s3_side_reg.fail | (prod_hi[W:H] != '0);
        s4_prod_next      = {prod_hi[H-1:0], s3_lo_reg[H-1:0]};
    end

    // stage 5: product times reciprocal, partial products
    logic           s5_valid_reg, s5_valid_next;
    cma_pkg::side_t s5_side_reg, s5_side_next;
    cma_pkg::word_t rp00_reg, rp00_next;
    cma_pkg::word_t rp01_reg, rp01_next;
    cma_pkg::word_t rp10_reg, rp10_next;
    cma_pkg::word_t rp11_reg, rp11_next;
    logic [H-1:0]   s5_plo_reg, s5_plo_next;

    always_comb
    begin
        s5_valid_next = s4_valid_reg;
        s5_side_next  = s4_side_reg;
        rp00_next     = W'(s4_prod_reg[H-1:0] * RECIP[H-1:0]);
        rp01_next     = W'(s4_prod_reg[H-1:0] * RECIP[W-1:H]);
        rp10_next     = W'(s4_prod_reg[W-1:H] * RECIP[H-1:0]);
        rp11_next     = W'(s4_prod_reg[W-1:H] * RECIP[W-1:H]);
        s5_plo_next   = s4_prod_reg[H-1:0];
    end

    // stage 6: middle terms of the reciprocal product
    logic           s6_valid_reg, s6_valid_next;
    cma_pkg::side_t s6_side_reg, s6_side_next;
    logic [W+1:0]   s6_rsum_reg, s6_rsum_next;
    cma_pkg::word_t s6_r11_reg, s6_r11_next;
    logic [H-1:0]   s6_plo_reg, s6_plo_next;

    always_comb
    begin
        s6_valid_next = s5_valid_reg;
        s6_side_next  = s5_side_reg;
        s6_rsum_next  = (W + 2)'(rp01_reg) + (W + 2)'(rp10_reg)
                      + (W + 2)'(rp00_reg[W-1:H]);
        s6_r11_next   = rp11_reg;
        s6_plo_next   = s5_plo_reg;
    end

    // stage 7: quotient estimate, true quotient or one below
    logic           s7_valid_reg, s7_valid_next;
    cma_pkg::side_t s7_side_reg, s7_side_next;
    cma_pkg::word_t s7_q_reg, s7_q_next;
    logic [H-1:0]   s7_plo_reg, s7_plo_next;

    always_comb
    begin
        s7_valid_next = s6_valid_reg;
        s7_side_next  = s6_side_reg;
        s7_q_next     = s6_r11_reg + W'(s6_rsum_reg[W+1:H]);
        s7_plo_next   = s6_plo_reg;
    end

    // stage 8: low bits of quotient times divisor
    logic           s8_valid_reg, s8_valid_next;
    cma_pkg::side_t s8_side_reg, s8_side_next;
    cma_pkg::word_t s8_q_reg, s8_q_next;
    logic [H-1:0]   s8_qd_reg, s8_qd_next;
    logic [H-1:0]   s8_plo_reg, s8_plo_next;

    always_comb
    begin
        s8_valid_next = s7_valid_reg;
        s8_side_next  = s7_side_reg;
        s8_q_next     = s7_q_reg;
        s8_qd_next    = H'(s7_q_reg[H-1:0] * DIVISOR);
        s8_plo_next   = s7_plo_reg;
    end

    // stage 9: remainder of the estimate, below twice the divisor
    logic           s9_valid_reg, s9_valid_next;
    cma_pkg::side_t s9_side_reg, s9_side_next;
    cma_pkg::word_t s9_q_reg, s9_q_next;
    logic [H-1:0]   s9_rem_reg, s9_rem_next;

    always_comb
    begin
        s9_valid_next = s8_valid_reg;
        s9_side_next  = s8_side_reg;
        s9_q_next     = s8_q_reg;
        s9_rem_next   = s8_plo_reg - s8_qd_reg;
    end

    // correction and rounding stage
    logic           r1_valid_reg, r1_valid_next;
    cma_pkg::side_t r1_side_reg, r1_side_next;
    cma_pkg::word_t r1_mag_reg, r1_mag_next;
    logic [W:0]     rounded;
    logic           rem_ge;
    logic [H-1:0]   rem_fix;
    logic           round_up;

    always_comb
    begin
        rem_ge   = (s9_rem_reg >= DIVISOR);
        rem_fix  = rem_ge ? (s9_rem_reg - DIVISOR) : s9_rem_reg;
        round_up = (rem_fix >= HALF_UP);
        rounded  = {1'b0, s9_q_reg} + (W + 1)'(rem_ge) + (W + 1)'(round_up);
        r1_valid_next     = s9_valid_reg;
        r1_side_next      = s9_side_reg;
        r1_side_next.fail = s9_side_reg.fail | rounded[W];
        r1_mag_next       = rounded[W-1:0];
    end

    // range check, sign and result select
    logic           fin_ok;
    cma_pkg::word_t fin_val;
    logic           mul_over;

    always_comb
    begin
        mul_over = r1_side_reg.neg ? (r1_mag_reg > cma_pkg::WORD_MIN) : r1_mag_reg[W-1];
        if (r1_side_reg.is_mul)
        begin
            fin_ok  = !r1_side_reg.fail && !mul_over;
            fin_val = r1_side_reg.neg ? (~r1_mag_reg + W'(1)) : r1_mag_reg;
        end
        else
        begin
            fin_ok  = r1_side_reg.simple_ok;
            fin_val = r1_side_reg.simple_val;
        end
        if (!fin_ok)
        begin
            fin_val = '0;
        end
    end

    // output register and skid
    logic           out_valid_reg, out_valid_next;
    logic           out_ok_reg, out_ok_next;
    cma_pkg::word_t out_value_reg, out_value_next;
    logic           skid_valid_reg, skid_valid_next;
    logic           skid_ok_reg, skid_ok_next;
    cma_pkg::word_t skid_value_reg, skid_value_next;
    logic           pop;

    assign en        = !skid_valid_reg;
    assign req.ready = en;
    assign pop       = out_valid_reg && rsp.ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_ok_next     = out_ok_reg;
        out_value_next  = out_value_reg;
        skid_valid_next = skid_valid_reg;
        skid_ok_next    = skid_ok_reg;
        skid_value_next = skid_value_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_ok_next     = skid_ok_reg;
                out_value_next  = skid_value_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (r1_valid_reg)
        begin
            if (!out_valid_reg || pop)
            begin
                out_valid_next = 1'b1;
                out_ok_next    = fin_ok;
                out_value_next = fin_val;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_ok_next    = fin_ok;
                skid_value_next = fin_val;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.ok    = out_ok_reg;
    assign rsp.value = out_value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            s4_valid_reg   <= 1'b0;
            s5_valid_reg   <= 1'b0;
            s6_valid_reg   <= 1'b0;
            s7_valid_reg   <= 1'b0;
            s8_valid_reg   <= 1'b0;
            s9_valid_reg   <= 1'b0;
            r1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
            if (en)
            begin
                s1_valid_reg <= s1_valid_next;
                s2_valid_reg <= s2_valid_next;
                s3_valid_reg <= s3_valid_next;
                s4_valid_reg <= s4_valid_next;
                s5_valid_reg <= s5_valid_next;
                s6_valid_reg <= s6_valid_next;
                s7_valid_reg <= s7_valid_next;
                s8_valid_reg <= s8_valid_next;
                s9_valid_reg <= s9_valid_next;
                r1_valid_reg <= r1_valid_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_ok_reg     <= out_ok_next;
        out_value_reg  <= out_value_next;
        skid_ok_reg    <= skid_ok_next;
        skid_value_reg <= skid_value_next;
        if (en)
        begin
            s1_side_reg <= s1_side_next;
            s1_ma_reg   <= s1_ma_next;
            s1_mb_reg   <= s1_mb_next;
            s2_side_reg <= s2_side_next;
            pp00_reg    <= pp00_next;
            pp01_reg    <= pp01_next;
            pp10_reg    <= pp10_next;
            pp11_reg    <= pp11_next;
            s3_side_reg <= s3_side_next;
            s3_mid_reg  <= s3_mid_next;
            s3_lo_reg   <= s3_lo_next;
            s4_side_reg <= s4_side_next;
            s4_prod_reg <= s4_prod_next;
            s5_side_reg <= s5_side_next;
            rp00_reg    <= rp00_next;
            rp01_reg    <= rp01_next;
            rp10_reg    <= rp10_next;
            rp11_reg    <= rp11_next;
            s5_plo_reg  <= s5_plo_next;
            s6_side_reg <= s6_side_next;
            s6_rsum_reg <= s6_rsum_next;
            s6_r11_reg  <= s6_r11_next;
            s6_plo_reg  <= s6_plo_next;
            s7_side_reg <= s7_side_next;
            s7_q_reg    <= s7_q_next;
            s7_plo_reg  <= s7_plo_next;
            s8_side_reg <= s8_side_next;
            s8_q_reg    <= s8_q_next;
            s8_qd_reg   <= s8_qd_next;
            s8_plo_reg  <= s8_plo_next;
            s9_side_reg <= s9_side_next;
            s9_q_reg    <= s9_q_next;
            s9_rem_reg  <= s9_rem_next;
            r1_side_reg <= r1_side_next;
            r1_mag_reg  <= r1_mag_next;
        end
    end

    // a failed result always carries a zero amount
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ok |-> rsp.value == '0)
        else $error("failed result with nonzero value");

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a beat while output is empty");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !rsp.ready))
        else $error("skid filled while output was free");

    a_mul_sign: assert property (@(posedge clk) disable iff (!rst_n)
        r1_valid_reg && r1_side_reg.is_mul && fin_ok && fin_val != '0
            |-> fin_val[W-1] == r1_side_reg.neg)
        else $error("multiply result sign mismatch");

endmodule

// File: dv/cma_checker.sv
module cma_checker #(
    parameter int unsigned SCALE = cma_pkg::SCALE_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    cma_req_if   req,
    cma_rsp_if   rsp,
    output int   fail_count,
    output int   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic           ok;
        cma_pkg::word_t value;
    } money_result_t;

    money_result_t pending_results[$];

    function automatic logic add_fits(input cma_pkg::word_t a, input cma_pkg::word_t b,
                                      output cma_pkg::word_t sum);
        sum = a + b;
        return !(((a ^ sum) & (b ^ sum)) & cma_pkg::WORD_MIN);
    endfunction

    function automatic cma_pkg::word_t magnitude(input cma_pkg::word_t v);
        return v[cma_pkg::WORD_W-1] ? -v : v;
    endfunction

    function automatic logic scaled_mul(input cma_pkg::word_t rate, input cma_pkg::word_t qty,
                                        output cma_pkg::word_t res);
        logic           neg;
        logic [127:0]   wide;
        cma_pkg::word_t prod;
        cma_pkg::word_t whole;
        cma_pkg::word_t rem;
        cma_pkg::word_t limit;
        neg  = rate[cma_pkg::WORD_W-1] ^ qty[cma_pkg::WORD_W-1];
        wide = {64'd0, magnitude(rate)} * {64'd0, magnitude(qty)};
        res  = '0;
        if (wide[127:64] != '0)
            return 1'b0;
        prod  = wide[63:0];
        whole = prod / SCALE;
        rem   = prod % SCALE;
        // round half away from zero on the magnitude
        if (rem * 2 >= SCALE)
        begin
            if (whole == '1)
                return 1'b0;
            whole = whole + 1;
        end
        limit = neg ? cma_pkg::WORD_MIN : ~cma_pkg::WORD_MIN;
        if (whole > limit)
            return 1'b0;
        res = neg ? -whole : whole;
        return 1'b1;
    endfunction

    function automatic money_result_t checked_result(input logic [cma_pkg::CMD_W-1:0] cmd,
                                                     input cma_pkg::word_t a,
                                                     input cma_pkg::word_t b);
        money_result_t  r;
        cma_pkg::word_t v;
        logic           ok;
        v = '0;
        case (cmd)
            cma_pkg::CMD_ADD: ok = add_fits(a, b, v);
            cma_pkg::CMD_SUB:
            begin
                // b is negated first, so the most negative b always fails
                if (b == cma_pkg::WORD_MIN)
                    ok = 1'b0;
                else
                    ok = add_fits(a, -b, v);
            end
            cma_pkg::CMD_NEG:
            begin
                ok = (a != cma_pkg::WORD_MIN);
                v  = -a;
            end
            default: ok = scaled_mul(a, b, v);
        endcase
        r.ok    = ok;
        r.value = ok ? v : '0;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] error: %s", $realtime, msg);
        fail_count++;
    endtask

    always @(posedge clk)
    begin
        money_result_t want;
        if (!rst_n)
        begin
            pending_results.delete();
        end
        else
        begin
            if (req.valid && req.ready)
                pending_results = {pending_results,
                                   checked_result(req.cmd, req.operand_a, req.operand_b)};
            if (rsp.valid && rsp.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result beat ok=%0b value=%0d",
                                              rsp.ok, rsp.value));
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (rsp.ok !== want.ok)
                        report_mismatch($sformatf("ok: got %0b, want %0b", rsp.ok, want.ok));
                    if (rsp.value !== want.value)
                        report_mismatch($sformatf("value: got %0d, want %0d",
                                                  rsp.value, $signed(want.value)));
                end
            end
        end
        outstanding <= pending_results.size();
    end

endmodule

// File: dv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SCALE        = cma_pkg::SCALE_DEFAULT;
    localparam int          CMD_W        = cma_pkg::CMD_W;
    localparam int          BEATS_PER_PHASE = 250;
    localparam int          IDLE_LIMIT   = 2000;
    localparam int          DRAIN_CYCLES = 60;

    localparam cma_pkg::word_t WORD_MIN = cma_pkg::WORD_MIN;
    localparam cma_pkg::word_t WORD_MAX = ~cma_pkg::WORD_MIN;

    logic clk = 1'b0;
    logic rst_n;
    int   idle_pct;
    int   stall_pct;
    int   fail_count;
    int   outstanding;
    int   quiet_cycles;

    cma_req_if req_ch ();
    cma_rsp_if rsp_ch ();

    checked_money_alu_core #(.SCALE(SCALE)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    cma_checker #(.SCALE(SCALE)) checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
        rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_beat(input logic [CMD_W-1:0] cmd, input cma_pkg::word_t a,
                             input cma_pkg::word_t b);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.cmd       <= cmd;
        req_ch.operand_a <= a;
        req_ch.operand_b <= b;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    function automatic cma_pkg::word_t rand_operand();
        cma_pkg::word_t v;
        case ($urandom_range(0, 4))
            0, 1: v = {$urandom, $urandom};
            2:
            begin
                v = cma_pkg::word_t'($urandom_range(0, 2000000));
                if ($urandom_range(0, 1))
                    v = -v;
            end
            3:
            begin
                case ($urandom_range(0, 6))
                    0: v = WORD_MIN;
                    1: v = WORD_MAX;
                    2: v = '0;
                    3: v = 64'd1;
                    4: v = '1;
                    5: v = WORD_MIN + 1;
                    default: v = WORD_MAX - 1;
                endcase
            end
            default:
            begin
                v = {$urandom, $urandom} >> $urandom_range(0, 63);
                if ($urandom_range(0, 1))
                    v = -v;
            end
        endcase
        return v;
    endfunction

    initial
    begin
        rst_n            = 1'b0;
        idle_pct         = 0;
        stall_pct        = 0;
        req_ch.valid     <= 1'b0;
        req_ch.cmd       <= cma_pkg::CMD_ADD;
        req_ch.operand_a <= '0;
        req_ch.operand_b <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // add and subtract edges
        send_beat(cma_pkg::CMD_ADD, WORD_MAX, 64'd1);
        send_beat(cma_pkg::CMD_ADD, WORD_MIN, '1);
        send_beat(cma_pkg::CMD_ADD, WORD_MAX, WORD_MIN);
        send_beat(cma_pkg::CMD_ADD, WORD_MIN, WORD_MIN);
        send_beat(cma_pkg::CMD_ADD, '0, '0);
        send_beat(cma_pkg::CMD_SUB, '1, WORD_MIN);
        send_beat(cma_pkg::CMD_SUB, '0, WORD_MIN);
        send_beat(cma_pkg::CMD_SUB, WORD_MIN, 64'd1);
        send_beat(cma_pkg::CMD_SUB, WORD_MAX, '1);
        send_beat(cma_pkg::CMD_SUB, WORD_MAX, WORD_MAX);
        // negate
        send_beat(cma_pkg::CMD_NEG, WORD_MIN, '0);
        send_beat(cma_pkg::CMD_NEG, WORD_MAX, '0);
        send_beat(cma_pkg::CMD_NEG, '0, WORD_MIN);
        send_beat(cma_pkg::CMD_NEG, '1, WORD_MAX);
        // multiply: width, rounding, zero, most negative
        send_beat(cma_pkg::CMD_MUL, WORD_MAX, WORD_MAX);
        send_beat(cma_pkg::CMD_MUL, 64'h1_0000_0000, 64'h1_0000_0000);
        send_beat(cma_pkg::CMD_MUL, 64'hFFFF_FFFF, 64'h1_0000_0001);
        send_beat(cma_pkg::CMD_MUL, 64'd1, 64'd500);
        send_beat(cma_pkg::CMD_MUL, 64'd1, 64'd499);
        send_beat(cma_pkg::CMD_MUL, '1, 64'd500);
        send_beat(cma_pkg::CMD_MUL, '1, -64'sd1499);
        send_beat(cma_pkg::CMD_MUL, WORD_MIN, '0);
        send_beat(cma_pkg::CMD_MUL, -64'sd7, '0);
        send_beat(cma_pkg::CMD_MUL, WORD_MIN, 64'd1);
        send_beat(cma_pkg::CMD_MUL, WORD_MIN, '1);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 84;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 84;
                end
                default:
                begin
                    idle_pct  = 10;
                    stall_pct = 10;
                end
            endcase
            repeat (BEATS_PER_PHASE)
                send_beat(CMD_W'($urandom_range(0, 3)), rand_operand(), rand_operand());
        end
        req_ch.valid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
